@@ src/prq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_pkg: shared types and constants of the priority ready-queue scheduler
// Request codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package prq_pkg;

	localparam int TASK_SLOTS_DEF      = 16;
	localparam int PRIORITY_LEVELS_DEF = 255;

	// request codes
	typedef enum logic [1:0] {
		REQ_ENQUEUE    = 2'd0,
		REQ_REMOVE     = 2'd1,
		REQ_RESCHEDULE = 2'd2,
		REQ_YIELD      = 2'd3
	} req_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ENQ_RD,
		ST_ENQ,
		ST_UNLINK_START,
		ST_WALK_LOAD,
		ST_WALK,
		ST_UNLINK_FIX,
		ST_SCAN,
		ST_PICK,
		ST_PICK_RD,
		ST_APPEND_OLD,
		ST_DONE
	} state_t;

endpackage

@@ src/priority_ready_queue_scheduler_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler_core: multilevel FIFO ready queue
// Keeps one linked list per priority level and the running task slot.
// ----------------------------------------------------------------------------
// One request beat at a time; s_tready is low while a request is in work and
// while its result beat waits, and comes back the cycle after the result beat
// is taken. A reschedule or yield that keeps the running task, and an early
// error, go from decode straight to the result; a pick that finds no queued
// task ends there with an error. An enqueue reads the level tail and then
// appends. A remove walks its level list one link a cycle to the slot at
// position k (k below TASK_SLOTS) and unlinks it. A switch picks the head of
// the most urgent level and unlinks it, then requeues the outgoing task if
// it is to stay ready. When a level empties, the level scanner steps one
// level a cycle up to the new most urgent level. Level heads and tails sit
// in memories with registered reads, so enqueue, pick and walk read first.
module priority_ready_queue_scheduler_core #(
	parameter int TASK_SLOTS      = prq_pkg::TASK_SLOTS_DEF,
	parameter int PRIORITY_LEVELS = prq_pkg::PRIORITY_LEVELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// req_type[1:0], task_id[5:2], task_level[13:6], current_leaving[14], zero
	input  logic [15:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[0], running_task[4:1], switched[5], top_level[13:6], zero
	output logic [15:0] m_tdata
);
	localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int LW = 8;

	prq_pkg::state_t st_q, st_n;

	// scheduler state
	logic [LW-1:0] slot_level_q [TASK_SLOTS];
	logic [SW-1:0] next_link_q  [TASK_SLOTS];
	logic [TASK_SLOTS-1:0] next_valid_q, queued_q;
	logic [PRIORITY_LEVELS:1] nonempty_q;
	logic [LW-1:0] urgent_q;
	logic [SW-1:0] run_q;
	logic          active_q;

	// level head and tail memories
	logic [SW-1:0] head_q [PRIORITY_LEVELS+1];
	logic [SW-1:0] tail_q [PRIORITY_LEVELS+1];
	logic [SW-1:0] head_rd_q, tail_rd_q;
	logic [LW-1:0] head_raddr;
	logic          head_we, tail_we;
	logic [SW-1:0] head_wdata, tail_wdata;

	// request registers
	prq_pkg::req_t req_q;
	logic [3:0]    id_raw_q;
	logic [LW-1:0] lvl_in_q;
	logic          leave_q;
	logic          err_q, sw_q;
	// unlink working registers
	logic [SW-1:0] tgt_q, cur_q, prev_q, old_q;
	logic [LW-1:0] ulvl_q;
	logic          has_prev_q, pick_mode_q, requeue_q;
	logic [SW:0]   cnt_q;

	logic scan_start, scan_done;
	logic [LW-1:0] scan_level;

	// decode helpers
	logic          s_accept;
	logic          id_ok, lvl_ok, enq_bad, resched_keep, yield_keep, pick_bad;
	logic          start_bad, walk_hit, walk_bad, ne_after_fix, requeue_now, enq_lvl_ok;
	logic [SW-1:0] id_s;
	logic [LW-1:0] run_lvl, tgt_lvl;
	logic [TASK_SLOTS-1:0] nv_fix, nv_enq;

	assign s_accept = s_tvalid && s_tready;
	assign id_ok    = ({28'd0, id_raw_q} < 32'(TASK_SLOTS));
	assign id_s     = SW'(id_raw_q);
	assign lvl_ok   = (lvl_in_q != '0) && ({24'd0, lvl_in_q} <= 32'(PRIORITY_LEVELS));
	assign run_lvl  = slot_level_q[run_q];
	assign tgt_lvl  = slot_level_q[tgt_q];
	assign enq_bad  = !id_ok || !lvl_ok || queued_q[id_s] || (active_q && id_s == run_q);
	assign resched_keep = active_q && !leave_q && (urgent_q >= run_lvl);
	assign yield_keep   = (run_lvl < urgent_q);
	assign pick_bad  = (urgent_q == '0) || !nonempty_q[urgent_q];
	assign start_bad = !queued_q[tgt_q] || (tgt_lvl == '0) || !nonempty_q[tgt_lvl];
	assign walk_hit  = (cur_q == tgt_q);
	assign walk_bad  = !next_valid_q[cur_q] || (cnt_q == (SW+1)'(TASK_SLOTS-1));
	// nonempty state of the unlinked level once the fix is applied
	assign ne_after_fix = has_prev_q || next_valid_q[tgt_q];
	assign requeue_now  = pick_mode_q && (tgt_q != old_q) && requeue_q;
	assign enq_lvl_ok   = (ulvl_q != '0) && ({24'd0, ulvl_q} <= 32'(PRIORITY_LEVELS));

	// link valid bits after an unlink fix or an append
	always_comb begin
		nv_fix = next_valid_q;
		if (has_prev_q) nv_fix[prev_q] = next_valid_q[tgt_q];
		nv_fix[tgt_q] = 1'b0;
		nv_enq = next_valid_q;
		if (nonempty_q[ulvl_q]) nv_enq[tail_rd_q] = 1'b1;
		nv_enq[tgt_q] = 1'b0;
	end

	prq_scan #(.PRIORITY_LEVELS(PRIORITY_LEVELS), .LW(LW)) u_scan (
		.clk(clk), .arst_n(arst_n), .start(scan_start),
		.nonempty(nonempty_q), .done(scan_done), .level(scan_level)
	);

	// next state
	always_comb begin
		st_n = st_q;
		case (st_q)
			prq_pkg::ST_IDLE:         if (s_accept) st_n = prq_pkg::ST_DECODE;
			prq_pkg::ST_DECODE: begin
				case (req_q)
					prq_pkg::REQ_ENQUEUE:
						st_n = enq_bad ? prq_pkg::ST_DONE : prq_pkg::ST_ENQ_RD;
					prq_pkg::REQ_REMOVE:
						st_n = id_ok ? prq_pkg::ST_UNLINK_START : prq_pkg::ST_DONE;
					prq_pkg::REQ_RESCHEDULE:
						st_n = resched_keep ? prq_pkg::ST_DONE : prq_pkg::ST_PICK;
					prq_pkg::REQ_YIELD:
						st_n = (!active_q || yield_keep) ? prq_pkg::ST_DONE : prq_pkg::ST_PICK;
					default: st_n = prq_pkg::ST_DONE;
				endcase
			end
			prq_pkg::ST_PICK:         st_n = pick_bad ? prq_pkg::ST_DONE : prq_pkg::ST_PICK_RD;
			prq_pkg::ST_PICK_RD:      st_n = prq_pkg::ST_UNLINK_START;
			prq_pkg::ST_UNLINK_START:
				st_n = start_bad ? prq_pkg::ST_DONE : prq_pkg::ST_WALK_LOAD;
			prq_pkg::ST_WALK_LOAD:    st_n = prq_pkg::ST_WALK;
			prq_pkg::ST_WALK: begin
				if (walk_hit) st_n = prq_pkg::ST_UNLINK_FIX;
				else if (walk_bad) st_n = prq_pkg::ST_DONE;
			end
			prq_pkg::ST_UNLINK_FIX:
				st_n = ne_after_fix ? prq_pkg::ST_APPEND_OLD : prq_pkg::ST_SCAN;
			prq_pkg::ST_SCAN:         if (scan_done) st_n = prq_pkg::ST_APPEND_OLD;
			prq_pkg::ST_APPEND_OLD:
				st_n = requeue_now ? prq_pkg::ST_ENQ_RD : prq_pkg::ST_DONE;
			prq_pkg::ST_ENQ_RD:       st_n = prq_pkg::ST_ENQ;
			prq_pkg::ST_ENQ:          st_n = prq_pkg::ST_DONE;
			prq_pkg::ST_DONE:         st_n = prq_pkg::ST_IDLE;
			default:                  st_n = prq_pkg::ST_IDLE;
		endcase
	end

	// handshake, scanner start and memory port controls
	always_comb begin
		s_tready   = (st_q == prq_pkg::ST_IDLE) && !m_tvalid;
		scan_start = (st_q == prq_pkg::ST_UNLINK_FIX) && !ne_after_fix;
		head_raddr = (st_q == prq_pkg::ST_PICK) ? urgent_q : tgt_lvl;
		head_we    = 1'b0;
		tail_we    = 1'b0;
		head_wdata = tgt_q;
		tail_wdata = tgt_q;
		case (st_q)
			prq_pkg::ST_UNLINK_FIX: begin
				head_wdata = next_link_q[tgt_q];
				tail_wdata = prev_q;
				head_we    = !has_prev_q && next_valid_q[tgt_q];
				tail_we    = has_prev_q && (tail_rd_q == tgt_q);
			end
			prq_pkg::ST_ENQ: begin
				head_we = enq_lvl_ok && !nonempty_q[ulvl_q];
				tail_we = enq_lvl_ok;
			end
			default: begin
				head_we = 1'b0;
				tail_we = 1'b0;
			end
		endcase
	end

	// level head and tail memories, registered reads
	always_ff @(posedge clk) begin
		if (head_we) head_q[ulvl_q] <= head_wdata;
		if (tail_we) tail_q[ulvl_q] <= tail_wdata;
		head_rd_q <= head_q[head_raddr];
		tail_rd_q <= tail_q[ulvl_q];
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= prq_pkg::ST_IDLE;
		else st_q <= st_n;
	end

	// main sequencer datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_valid_q <= '0;
			queued_q     <= '0;
			nonempty_q   <= '0;
			urgent_q     <= LW'(PRIORITY_LEVELS);
			run_q        <= '0;
			active_q     <= 1'b1;
			m_tvalid     <= 1'b0;
			req_q        <= prq_pkg::REQ_ENQUEUE;
			id_raw_q     <= '0;
			lvl_in_q     <= '0;
			leave_q      <= 1'b0;
			err_q        <= 1'b0;
			sw_q         <= 1'b0;
			tgt_q        <= '0;
			cur_q        <= '0;
			prev_q       <= '0;
			old_q        <= '0;
			ulvl_q       <= '0;
			has_prev_q   <= 1'b0;
			pick_mode_q  <= 1'b0;
			requeue_q    <= 1'b0;
			cnt_q        <= '0;
			for (int i = 0; i < TASK_SLOTS; i++) begin
				slot_level_q[i] <= LW'(PRIORITY_LEVELS);
				next_link_q[i]  <= '0;
			end
		end else begin
			case (st_q)
				prq_pkg::ST_IDLE: begin
					if (m_tvalid && m_tready) m_tvalid <= 1'b0;
					else if (s_accept) begin
						req_q    <= prq_pkg::req_t'(s_tdata[1:0]);
						id_raw_q <= s_tdata[5:2];
						lvl_in_q <= s_tdata[13:6];
						leave_q  <= s_tdata[14];
						err_q    <= 1'b0;
						sw_q     <= 1'b0;
					end
				end
				prq_pkg::ST_DECODE: begin
					case (req_q)
						prq_pkg::REQ_ENQUEUE: begin
							if (enq_bad) err_q <= 1'b1;
							else begin
								slot_level_q[id_s] <= lvl_in_q;
								tgt_q <= id_s;
								ulvl_q <= lvl_in_q;
							end
						end
						prq_pkg::REQ_REMOVE: begin
							if (!id_ok) err_q <= 1'b1;
							else begin
								tgt_q <= id_s;
								pick_mode_q <= 1'b0;
							end
						end
						prq_pkg::REQ_RESCHEDULE: begin
							if (leave_q) active_q <= 1'b0;
							if (!resched_keep) requeue_q <= active_q && !leave_q;
						end
						prq_pkg::REQ_YIELD: begin
							if (!active_q) err_q <= 1'b1;
							else if (!yield_keep) requeue_q <= 1'b1;
						end
						default: err_q <= 1'b1;
					endcase
				end
				// pick: head of most urgent level, then unlink it
				prq_pkg::ST_PICK: begin
					if (pick_bad) err_q <= 1'b1;
					else begin
						old_q <= run_q;
						pick_mode_q <= 1'b1;
					end
				end
				prq_pkg::ST_PICK_RD: tgt_q <= head_rd_q;
				prq_pkg::ST_UNLINK_START: begin
					ulvl_q <= tgt_lvl;
					if (start_bad) err_q <= 1'b1;
				end
				prq_pkg::ST_WALK_LOAD: begin
					cur_q <= head_rd_q;
					has_prev_q <= 1'b0;
					cnt_q <= '0;
				end
				// one link per cycle
				prq_pkg::ST_WALK: begin
					if (!walk_hit) begin
						if (walk_bad) err_q <= 1'b1;
						else begin
							prev_q <= cur_q;
							has_prev_q <= 1'b1;
							cur_q <= next_link_q[cur_q];
							cnt_q <= cnt_q + (SW+1)'(1);
						end
					end
				end
				prq_pkg::ST_UNLINK_FIX: begin
					if (!has_prev_q) begin
						if (!next_valid_q[tgt_q]) nonempty_q[ulvl_q] <= 1'b0;
					end else next_link_q[prev_q] <= next_link_q[tgt_q];
					next_valid_q <= nv_fix;
					queued_q[tgt_q] <= 1'b0;
				end
				prq_pkg::ST_SCAN: begin
					if (scan_done) urgent_q <= scan_level;
				end
				// finish a pick: run it and, when requeue_now holds, requeue the outgoing task
				prq_pkg::ST_APPEND_OLD: begin
					if (pick_mode_q) begin
						run_q <= tgt_q;
						active_q <= 1'b1;
						sw_q <= (tgt_q != old_q);
						if (requeue_now) begin
							ulvl_q <= slot_level_q[old_q];
							tgt_q <= old_q;
						end
					end
				end
				prq_pkg::ST_ENQ: begin
					if (enq_lvl_ok) begin
						if (nonempty_q[ulvl_q]) next_link_q[tail_rd_q] <= tgt_q;
						next_valid_q <= nv_enq;
						nonempty_q[ulvl_q] <= 1'b1;
						queued_q[tgt_q] <= 1'b1;
						if (ulvl_q < urgent_q) urgent_q <= ulvl_q;
					end
				end
				prq_pkg::ST_DONE: m_tvalid <= 1'b1;
				default: m_tvalid <= m_tvalid;
			endcase
		end
	end

	// result beat fields
	always_comb begin
		m_tdata = {2'b00, urgent_q, sw_q, 4'(run_q), err_q};
	end
endmodule

@@ src/prq_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_scan: most urgent level search
// Walks the nonempty flags one level a cycle from level one upward.
// ----------------------------------------------------------------------------
module prq_scan #(
	parameter int PRIORITY_LEVELS = prq_pkg::PRIORITY_LEVELS_DEF,
	parameter int LW = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [PRIORITY_LEVELS:1]   nonempty,
	output logic                       done,
	output logic [LW-1:0]              level
);
	logic [LW-1:0] idx_q;
	logic          busy_q;
	logic          hit;
	logic          last;

	assign hit  = nonempty[idx_q];
	assign last = (idx_q == LW'(PRIORITY_LEVELS));
	assign done = busy_q && (hit || last);
	assign level = hit ? idx_q : LW'(PRIORITY_LEVELS);

	// one level per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= LW'(1);
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= LW'(1);
		end else if (busy_q) begin
			if (hit || last) busy_q <= 1'b0;
			else idx_q <= idx_q + LW'(1);
		end
	end
endmodule

@@ src/prq_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_checker: port-level checks of the scheduler
// Watches both stream sides for handshake and result rules.
// ----------------------------------------------------------------------------
module prq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);
	// result beat holds while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// no new request while a result waits
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("request taken with result pending");

	// a taken request is not ready next cycle
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready right after request");

	// top level never zero and the two top bits zero
	a_top: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[13:6] != 8'd0 && m_tdata[15:14] == 2'd0)
		else $error("bad result fields");
endmodule

bind priority_ready_queue_scheduler_core prq_checker u_prq_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
